@@ rtl/core/calendar_date_counter_macros.svh @@
// Assertion helpers for the calendar date counter
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CALDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date counter: check failed");

// Next-cycle implication, disabled in reset
`define CALDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date counter: check failed");

`endif

@@ rtl/core/caldc_pkg.sv @@
package caldc_pkg;

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_BACK = 2'd2,
        KIND_DIFF = 2'd3
    } kind_t;

    typedef struct packed {
        logic [3:0]  month;
        logic [5:0]  day;
        logic [13:0] year;
        logic        valid;
    } date_t;

    // floor(y / 100) by reciprocal, exact for 14-bit y
    function automatic logic [7:0] div100(input logic [13:0] y);
        logic [26:0] p;
        p = 27'(y) * 27'd5243;
        return p[26:19];
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [7:0]  q;
        logic [13:0] r;
        q = div100(y);
        r = y - 14'(q) * 14'd100;
        return ((y[1:0] == 2'b00) && (r != 14'd0)) || ((r == 14'd0) && (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] n;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = is_leap(y) ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic check_date(input logic [3:0] m, input logic [5:0] d,
                                        input logic [13:0] y);
        return (m >= 4'd1) && (m <= MONTH_MAX) && (y >= YEAR_MIN) && (y <= YEAR_MAX)
            && (d >= 6'd1) && (d <= {1'b0, days_in(m, y)});
    endfunction

    // days before the shifted month, year starting in March
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] v;
        case (mm)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // day number of a valid date
    function automatic logic [21:0] day_number(input logic [3:0] m, input logic [5:0] d,
                                               input logic [13:0] y);
        logic [3:0]  mm;
        logic [13:0] yy;
        logic [7:0]  q;
        logic [21:0] n;
        mm = (m <= 4'd2) ? m + 4'd9 : m - 4'd3;
        yy = (m <= 4'd2) ? y - 14'd1 : y;
        q  = div100(yy);
        n  = 22'(yy) * 22'd365 + 22'(yy[13:2]) - 22'(q) + 22'(q[7:2])
           + 22'(month_offset(mm)) + 22'(d) - 22'd1;
        return n;
    endfunction

endpackage

@@ rtl/core/caldc_step.sv @@
module caldc_step (
    input  caldc_pkg::kind_t kind,
    input  caldc_pkg::date_t cur,
    input  logic [3:0]       month_in,
    input  logic [5:0]       day_in,
    input  logic [13:0]      year_in,
    output caldc_pkg::date_t nxt
);

    logic [4:0] len_cur;
    logic [4:0] len_prev;

    assign len_cur  = caldc_pkg::days_in(cur.month, cur.year);
    assign len_prev = caldc_pkg::days_in(cur.month - 4'd1, cur.year);

    always_comb
    begin
        nxt = cur;
        unique case (kind)
            caldc_pkg::KIND_LOAD:
            begin
                nxt.month = month_in;
                nxt.day   = day_in;
                nxt.year  = year_in;
                nxt.valid = caldc_pkg::check_date(month_in, day_in, year_in);
            end
            caldc_pkg::KIND_FWD:
            begin
                if (cur.valid)
                begin
                    if (cur.day < {1'b0, len_cur})
                    begin
                        nxt.day = cur.day + 6'd1;
                    end
                    else if (cur.month < caldc_pkg::MONTH_MAX)
                    begin
                        nxt.month = cur.month + 4'd1;
                        nxt.day   = 6'd1;
                    end
                    else if (cur.year < caldc_pkg::YEAR_MAX)
                    begin
                        nxt.year  = cur.year + 14'd1;
                        nxt.month = 4'd1;
                        nxt.day   = 6'd1;
                    end
                    else
                    begin
                        nxt.valid = 1'b0;
                    end
                end
            end
            caldc_pkg::KIND_BACK:
            begin
                if (cur.valid)
                begin
                    if (cur.day > 6'd1)
                    begin
                        nxt.day = cur.day - 6'd1;
                    end
                    else if (cur.month > 4'd1)
                    begin
                        nxt.month = cur.month - 4'd1;
                        nxt.day   = {1'b0, len_prev};
                    end
                    else if (cur.year > caldc_pkg::YEAR_MIN)
                    begin
                        nxt.year  = cur.year - 14'd1;
                        nxt.month = caldc_pkg::MONTH_MAX;
                        nxt.day   = 6'd31;
                    end
                    else
                    begin
                        nxt.valid = 1'b0;
                    end
                end
            end
            caldc_pkg::KIND_DIFF:
            begin
                nxt = cur;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

@@ rtl/core/caldc_diff.sv @@
module caldc_diff (
    input  caldc_pkg::kind_t    kind,
    input  caldc_pkg::date_t    cur,
    input  logic [3:0]          month_in,
    input  logic [5:0]          day_in,
    input  logic [13:0]         year_in,
    output logic signed [22:0]  diff
);

    logic [21:0] dn_cur;
    logic [21:0] dn_sup;
    logic        sup_ok;

    assign dn_cur = caldc_pkg::day_number(cur.month, cur.day, cur.year);
    assign dn_sup = caldc_pkg::day_number(month_in, day_in, year_in);
    assign sup_ok = caldc_pkg::check_date(month_in, day_in, year_in);

    always_comb
    begin
        if ((kind == caldc_pkg::KIND_DIFF) && cur.valid && sup_ok)
        begin
            diff = $signed({1'b0, dn_cur}) - $signed({1'b0, dn_sup});
        end
        else
        begin
            diff = 23'sd0;
        end
    end

endmodule

@@ rtl/core/calendar_date_counter.sv @@
// An input transfer is held in the input register, then moved to the result register.
// One item per cycle unless out_ready stalls; state and result update in the same cycle.
// Reset (rst_n low, asynchronous): date cleared to 0/0/0 and marked invalid,
// both pipeline stages emptied.
`include "calendar_date_counter_macros.svh"

module calendar_date_counter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [3:0]         month_in,
    input  logic [5:0]         day_in,
    input  logic [13:0]        year_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         month_out,
    output logic [5:0]         day_out,
    output logic [13:0]        year_out,
    output logic               date_valid,
    output logic signed [22:0] day_difference
);

    logic                    s1_valid_reg;
    caldc_pkg::kind_t        s1_kind_reg;
    logic [3:0]              s1_month_reg;
    logic [5:0]              s1_day_reg;
    logic [13:0]             s1_year_reg;

    caldc_pkg::date_t        cur_reg;
    caldc_pkg::date_t        cur_next;

    logic                    out_valid_reg;
    caldc_pkg::date_t        out_date_reg;
    logic signed [22:0]      out_diff_reg;
    logic signed [22:0]      diff_next;

    logic                    out_adv;
    logic                    fire;

    assign out_adv  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && out_adv;
    assign in_ready = !s1_valid_reg || out_adv;

    caldc_step u_step (
        .kind     (s1_kind_reg),
        .cur      (cur_reg),
        .month_in (s1_month_reg),
        .day_in   (s1_day_reg),
        .year_in  (s1_year_reg),
        .nxt      (cur_next)
    );

    caldc_diff u_diff (
        .kind     (s1_kind_reg),
        .cur      (cur_reg),
        .month_in (s1_month_reg),
        .day_in   (s1_day_reg),
        .year_in  (s1_year_reg),
        .diff     (diff_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_kind_reg  <= caldc_pkg::kind_t'(kind);
            s1_month_reg <= month_in;
            s1_day_reg   <= day_in;
            s1_year_reg  <= year_in;
        end
    end

    // stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (fire)
        begin
            cur_reg <= cur_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_date_reg <= cur_next;
            out_diff_reg <= diff_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign month_out      = out_date_reg.month;
    assign day_out        = out_date_reg.day;
    assign year_out       = out_date_reg.year;
    assign date_valid     = out_date_reg.valid;
    assign day_difference = out_diff_reg;

    `CALDC_ASSERT_IMPL(a_valid_date_in_range, clk, rst_n, out_valid_reg && out_date_reg.valid,
        (out_date_reg.month >= 4'd1) && (out_date_reg.month <= caldc_pkg::MONTH_MAX)
        && (out_date_reg.day != 6'd0) && (out_date_reg.year != 14'd0)
        && (out_date_reg.year <= caldc_pkg::YEAR_MAX))
    `CALDC_ASSERT_IMPL(a_diff_needs_valid, clk, rst_n,
        out_valid_reg && (out_diff_reg != 23'sd0), out_date_reg.valid)
    `CALDC_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !fire, $stable(cur_reg))
    `CALDC_ASSERT_NEXT(a_result_matches_state, clk, rst_n, fire,
        out_valid_reg && (out_date_reg == cur_reg))

endmodule

@@ tb/calendar_date_counter_tb.sv @@
`timescale 1ns / 1ps

module calendar_date_counter_tb;

    localparam int TOTAL_ITEMS = 1725;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic [3:0]         month;
        logic [5:0]         day;
        logic [13:0]        year;
        logic               valid;
        logic signed [22:0] diff;
    } date_result_t;

    typedef struct {
        caldc_pkg::kind_t k;
        logic [3:0]       m;
        logic [5:0]       d;
        logic [13:0]      y;
        bit               typed;
        date_result_t     res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         kind = 2'd0;
    logic [3:0]         month_in = 4'd0;
    logic [5:0]         day_in = 6'd0;
    logic [13:0]        year_in = 14'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         month_out;
    logic [5:0]         day_out;
    logic [13:0]        year_out;
    logic               date_valid;
    logic signed [22:0] day_difference;

    // predictor state
    logic [3:0]  cal_month = 4'd0;
    logic [5:0]  cal_day = 6'd0;
    logic [13:0] cal_year = 14'd0;
    bit          cal_valid = 1'b0;

    date_result_t pending_dates[$];
    stim_row_t    directed_rows[$];
    date_result_t none_res;

    bit quiet = 1'b0;
    int fail_count = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    int results_checked = 0;
    int n_load = 0;
    int n_load_ok = 0;
    int n_fwd = 0;
    int n_back = 0;
    int n_diff = 0;
    int n_diff_live = 0;
    int n_bound_hits = 0;

    calendar_date_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .month_in       (month_in),
        .day_in         (day_in),
        .year_in        (year_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .month_out      (month_out),
        .day_out        (day_out),
        .year_out       (year_out),
        .date_valid     (date_valid),
        .day_difference (day_difference)
    );

    always #2 clk = ~clk;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit legal_date(int m, int d, int y);
        return (m >= 1) && (m <= 12) && (y >= 1) && (y <= 9999)
            && (d >= 1) && (d <= month_days(m, y));
    endfunction

    // days since a fixed origin, year taken to start in March
    function automatic int serial_day(int m, int d, int y);
        int mm;
        int yy;
        mm = (m + 9) % 12;
        yy = y - mm / 10;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (306 * mm + 5) / 10 + d - 1;
    endfunction

    function automatic date_result_t advance_calendar(caldc_pkg::kind_t k, logic [3:0] m,
                                                      logic [5:0] d, logic [13:0] y);
        date_result_t r;
        int diff;
        diff = 0;
        case (k)
            caldc_pkg::KIND_LOAD:
            begin
                cal_month = m;
                cal_day   = d;
                cal_year  = y;
                cal_valid = legal_date(m, d, y);
            end
            caldc_pkg::KIND_FWD:
            begin
                if (cal_valid)
                begin
                    if (cal_day < month_days(cal_month, cal_year))
                        cal_day = cal_day + 6'd1;
                    else if (cal_month < 4'd12)
                    begin
                        cal_month = cal_month + 4'd1;
                        cal_day   = 6'd1;
                    end
                    else if (cal_year < 14'd9999)
                    begin
                        cal_year  = cal_year + 14'd1;
                        cal_month = 4'd1;
                        cal_day   = 6'd1;
                    end
                    else
                        cal_valid = 1'b0;
                end
            end
            caldc_pkg::KIND_BACK:
            begin
                if (cal_valid)
                begin
                    if (cal_day > 6'd1)
                        cal_day = cal_day - 6'd1;
                    else if (cal_month > 4'd1)
                    begin
                        cal_month = cal_month - 4'd1;
                        cal_day   = 6'(month_days(cal_month, cal_year));
                    end
                    else if (cal_year > 14'd1)
                    begin
                        cal_year  = cal_year - 14'd1;
                        cal_month = 4'd12;
                        cal_day   = 6'd31;
                    end
                    else
                        cal_valid = 1'b0;
                end
            end
            default:
            begin
                if (cal_valid && legal_date(m, d, y))
                    diff = serial_day(cal_month, cal_day, cal_year) - serial_day(m, d, y);
            end
        endcase
        r.month = cal_month;
        r.day   = cal_day;
        r.year  = cal_year;
        r.valid = cal_valid;
        r.diff  = 23'(diff);
        return r;
    endfunction

    function automatic date_result_t exp_date(int m, int d, int y, bit v);
        date_result_t r;
        r.month = 4'(m);
        r.day   = 6'(d);
        r.year  = 14'(y);
        r.valid = v;
        r.diff  = '0;
        return r;
    endfunction

    // legal date, biased toward month, year and range ends
    function automatic date_result_t pick_legal_date();
        date_result_t r;
        int sel;
        int y;
        int m;
        int len;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return exp_date(12, $urandom_range(24, 31), 9999, 1'b1);
        if (sel == 1)
            return exp_date(1, $urandom_range(1, 6), 1, 1'b1);
        if (sel <= 3)
        begin
            case ($urandom_range(0, 7))
                0:       y = 1600;
                1:       y = 1700;
                2:       y = 1900;
                3:       y = 2000;
                4:       y = 2100;
                5:       y = 2400;
                6:       y = 2024;
                default: y = 2023;
            endcase
        end
        else
            y = $urandom_range(1, 9999);
        m   = $urandom_range(1, 12);
        len = month_days(m, y);
        case ($urandom_range(0, 3))
            0:       r = exp_date(m, len - $urandom_range(0, 2), y, 1'b1);
            1:       r = exp_date(m, 1 + $urandom_range(0, 2), y, 1'b1);
            default: r = exp_date(m, $urandom_range(1, len), y, 1'b1);
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    task automatic add_row(caldc_pkg::kind_t k, int m, int d, int y, bit typed,
                           date_result_t res);
        stim_row_t row;
        row.k     = k;
        row.m     = 4'(m);
        row.d     = 6'(d);
        row.y     = 14'(y);
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_date_item(caldc_pkg::kind_t k, logic [3:0] m, logic [5:0] d,
                                  logic [13:0] y, bit typed, date_result_t typed_res);
        int gap;
        bit was_valid;
        date_result_t pred;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = k;
        month_in = m;
        day_in   = d;
        year_in  = y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        was_valid = cal_valid;
        pred = advance_calendar(k, m, d, y);
        pending_dates.push_back(typed ? typed_res : pred);
        items_sent++;
        case (k)
            caldc_pkg::KIND_LOAD:
            begin
                n_load++;
                if (pred.valid)
                    n_load_ok++;
            end
            caldc_pkg::KIND_FWD:  n_fwd++;
            caldc_pkg::KIND_BACK: n_back++;
            default:
            begin
                n_diff++;
                if (pred.diff != 0)
                    n_diff_live++;
            end
        endcase
        if (k inside {caldc_pkg::KIND_FWD, caldc_pkg::KIND_BACK} && was_valid && !pred.valid)
            n_bound_hits++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        date_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d valid %0b",
                         $time, month_out, day_out, year_out, date_valid);
                fail_count++;
            end
            else
            begin
                e = pending_dates.pop_front();
                results_checked++;
                check_field("month_out", e.month, month_out);
                check_field("day_out", e.day, day_out);
                check_field("year_out", e.year, year_out);
                check_field("date_valid", e.valid, date_valid);
                check_field("day_difference", e.diff, day_difference);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        date_result_t a;
        date_result_t b;
        caldc_pkg::kind_t dir;
        caldc_pkg::kind_t other;
        int run_len;
        int len;
        int sel;
        bit pressure_done;

        pressure_done = 1'b0;
        none_res = exp_date(0, 0, 0, 1'b0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(caldc_pkg::KIND_FWD, 0, 0, 0, 1, exp_date(0, 0, 0, 0));
        add_row(caldc_pkg::KIND_DIFF, 1, 1, 2000, 1, exp_date(0, 0, 0, 0));
        add_row(caldc_pkg::KIND_LOAD, 12, 31, 9999, 1, exp_date(12, 31, 9999, 1));
        add_row(caldc_pkg::KIND_FWD, 0, 0, 0, 1, exp_date(12, 31, 9999, 0));
        add_row(caldc_pkg::KIND_FWD, 0, 0, 0, 1, exp_date(12, 31, 9999, 0));
        add_row(caldc_pkg::KIND_LOAD, 1, 1, 1, 1, exp_date(1, 1, 1, 1));
        add_row(caldc_pkg::KIND_BACK, 15, 63, 16383, 1, exp_date(1, 1, 1, 0));
        add_row(caldc_pkg::KIND_LOAD, 2, 29, 2000, 1, exp_date(2, 29, 2000, 1));
        add_row(caldc_pkg::KIND_FWD, 0, 0, 0, 0, none_res);
        add_row(caldc_pkg::KIND_BACK, 0, 0, 0, 0, none_res);
        add_row(caldc_pkg::KIND_LOAD, 2, 29, 1900, 1, exp_date(2, 29, 1900, 0));
        add_row(caldc_pkg::KIND_LOAD, 2, 29, 2024, 1, exp_date(2, 29, 2024, 1));
        add_row(caldc_pkg::KIND_LOAD, 15, 63, 16383, 1, exp_date(15, 63, 16383, 0));
        add_row(caldc_pkg::KIND_BACK, 0, 0, 0, 1, exp_date(15, 63, 16383, 0));
        add_row(caldc_pkg::KIND_LOAD, 0, 0, 0, 1, exp_date(0, 0, 0, 0));
        add_row(caldc_pkg::KIND_LOAD, 1, 1, 1, 1, exp_date(1, 1, 1, 1));
        add_row(caldc_pkg::KIND_DIFF, 12, 31, 9999, 0, none_res);
        add_row(caldc_pkg::KIND_DIFF, 13, 1, 2000, 1, exp_date(1, 1, 1, 1));
        add_row(caldc_pkg::KIND_DIFF, 2, 30, 2000, 1, exp_date(1, 1, 1, 1));
        add_row(caldc_pkg::KIND_DIFF, 1, 1, 0, 1, exp_date(1, 1, 1, 1));
        add_row(caldc_pkg::KIND_LOAD, 12, 31, 9999, 1, exp_date(12, 31, 9999, 1));
        add_row(caldc_pkg::KIND_DIFF, 1, 1, 1, 0, none_res);
        add_row(caldc_pkg::KIND_LOAD, 12, 31, 2023, 1, exp_date(12, 31, 2023, 1));
        add_row(caldc_pkg::KIND_FWD, 0, 0, 0, 0, none_res);
        add_row(caldc_pkg::KIND_BACK, 0, 0, 0, 0, none_res);
        add_row(caldc_pkg::KIND_LOAD, 3, 1, 2023, 1, exp_date(3, 1, 2023, 1));
        add_row(caldc_pkg::KIND_BACK, 0, 0, 0, 0, none_res);

        @(negedge clk);
        foreach (directed_rows[i])
            send_date_item(directed_rows[i].k, directed_rows[i].m, directed_rows[i].d,
                           directed_rows[i].y, directed_rows[i].typed, directed_rows[i].res);

        in_valid = 1'b0;
        while (pending_dates.size() != 0)
            @(negedge clk);

        while (items_sent < TOTAL_ITEMS)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            if (!pressure_done && items_sent > TOTAL_ITEMS / 2)
            begin
                in_valid = 1'b0;
                while (pending_dates.size() != 0)
                    @(negedge clk);
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                // load a legal date, then walk it with mostly one direction
                a = pick_legal_date();
                send_date_item(caldc_pkg::KIND_LOAD, a.month, a.day, a.year, 0, none_res);
                dir   = $urandom_range(0, 1) ? caldc_pkg::KIND_FWD : caldc_pkg::KIND_BACK;
                other = (dir == caldc_pkg::KIND_FWD) ? caldc_pkg::KIND_BACK : caldc_pkg::KIND_FWD;
                run_len = $urandom_range(1, 40);
                repeat (run_len)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 7)
                        send_date_item(dir, 4'($urandom), 6'($urandom), 14'($urandom),
                                       0, none_res);
                    else if (sel < 9)
                        send_date_item(other, 4'($urandom), 6'($urandom), 14'($urandom),
                                       0, none_res);
                    else
                    begin
                        if ($urandom_range(0, 4) != 0)
                            b = pick_legal_date();
                        else
                            b = exp_date($urandom_range(0, 15), $urandom_range(0, 63),
                                         $urandom_range(0, 16383), 1'b0);
                        send_date_item(caldc_pkg::KIND_DIFF, b.month, b.day, b.year,
                                       0, none_res);
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        // one day past the end of the month
                        a = exp_date($urandom_range(1, 12), 0, $urandom_range(1, 9999), 1'b0);
                        len = month_days(a.month, a.year);
                        send_date_item(caldc_pkg::KIND_LOAD, a.month, 6'(len + 1), a.year,
                                       0, none_res);
                    end
                    else
                        send_date_item(caldc_pkg::kind_t'($urandom_range(0, 3)),
                                       4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                                       14'($urandom_range(0, 16383)), 0, none_res);
                end
            end
        end

        in_valid = 1'b0;
        quiet = 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d transfers: %0d loads (%0d legal), %0d forward, %0d back, %0d diffs",
                 items_sent, n_load, n_load_ok, n_fwd, n_back, n_diff);
        $display("%0d nonzero differences, %0d steps off the year range, %0d results checked",
                 n_diff_live, n_bound_hits, results_checked);
        if (fail_count == 0 && pending_dates.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ calendar_date_counter.f @@
+incdir+rtl/core
rtl/core/caldc_pkg.sv
rtl/core/caldc_step.sv
rtl/core/caldc_diff.sv
rtl/core/calendar_date_counter.sv
tb/calendar_date_counter_tb.sv
